// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the signal pending mask unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while arst_n is low.
`define SIGPM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off while arst_n is low.
`define SIGPM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sigpm_pkg.sv -----
// Types and constants shared by the signal pending mask unit.
package sigpm_pkg;

	typedef enum logic [2:0] {
		FUNC_RAISE      = 3'd0,
		FUNC_DEQUEUE    = 3'd1,
		FUNC_BLOCK      = 3'd2,
		FUNC_UNBLOCK    = 3'd3,
		FUNC_SET_MASK   = 3'd4,
		FUNC_READ_PEND  = 3'd5,
		FUNC_CLEAR_PEND = 3'd6
	} sigpm_func_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_INVAL = 2'd1,
		STATUS_AGAIN = 2'd2
	} sigpm_status_t;

	typedef enum logic [1:0] {
		RUN_RUNNING = 2'd0,
		RUN_STOPPED = 2'd1,
		RUN_ZOMBIE  = 2'd2
	} sigpm_run_t;

	typedef enum logic {
		CTRL_IDLE,
		CTRL_EXEC
	} sigpm_state_t;

	// Signals with a fixed effect on the run state.
	localparam logic [7:0] SIG_STOP = 8'd19;
	localparam logic [7:0] SIG_CONT = 8'd18;
	localparam logic [7:0] SIG_TERM = 8'd15;
	localparam logic [7:0] SIG_KILL = 8'd9;
	localparam logic [7:0] SIG_INT  = 8'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} sigpm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} sigpm_stat_t;

endpackage

// ----- rtl/sigpm_ctrl.sv -----
// Controller state machine of the signal pending mask unit.
module sigpm_ctrl
	import sigpm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  sigpm_stat_t stat,
	output sigpm_cmd_t  cmd
);

	sigpm_state_t state_q;
	sigpm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTRL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CTRL_IDLE: begin
				if (req_valid) begin
					state_d = CTRL_EXEC;
				end
			end
			CTRL_EXEC: begin
				if (stat.out_free) begin
					state_d = CTRL_IDLE;
				end
			end
			default: state_d = CTRL_IDLE;
		endcase
	end

	always_comb begin
		req_ready   = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			CTRL_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			CTRL_EXEC: begin
				cmd.commit = stat.out_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/sigpm_dpath.sv -----
// Datapath of the signal pending mask unit: request, signal state and result registers.
module sigpm_dpath
	import sigpm_pkg::*;
#(
	parameter int NUM_SIGNALS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  sigpm_cmd_t  cmd,
	output sigpm_stat_t stat,
	input  logic [71:0] req_data,
	input  logic [2:0]  req_user,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [79:0] res_data,
	output logic [1:0]  res_user
);

	localparam logic [7:0]  NumSigW   = 8'(NUM_SIGNALS);
	// Signals 1 to NUM_SIGNALS-1 take part in dequeue.
	localparam logic [63:0] ScopeMask = ((64'd1 << NUM_SIGNALS) - 64'd1) & ~64'd1;

	logic [2:0]  req_func_q;
	logic [7:0]  req_sig_q;
	logic [63:0] req_mask_q;

	logic [63:0] pending_q;
	logic [63:0] blocked_q;
	logic [1:0]  run_q;
	logic [5:0]  term_q;
	logic        exited_q;

	logic        out_vld_q;
	logic [1:0]  out_status_q;
	logic [5:0]  out_sig_q;
	logic [63:0] out_mask_q;

	logic [63:0] pending_d;
	logic [63:0] blocked_d;
	logic [1:0]  run_d;
	logic [5:0]  term_d;
	logic        exited_d;
	logic [1:0]  status_d;
	logic [5:0]  sig_d;
	logic [63:0] mask_d;

	logic [63:0] ready_bits;
	logic [63:0] lowest_bit;
	logic [5:0]  lowest_idx;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_func_q <= req_user;
			req_sig_q  <= req_data[7:0];
			req_mask_q <= req_data[71:8];
		end
	end

	// Lowest deliverable signal: isolate the lowest set bit, then encode it.
	always_comb begin
		ready_bits = pending_q & ~blocked_q & ~req_mask_q & ScopeMask;
		lowest_bit = ready_bits & (~ready_bits + 64'd1);
		lowest_idx = '0;
		for (int i = 0; i < 64; i++) begin
			if (lowest_bit[i]) begin
				lowest_idx = lowest_idx | 6'(i);
			end
		end
	end

	always_comb begin
		pending_d = pending_q;
		blocked_d = blocked_q;
		run_d     = run_q;
		term_d    = term_q;
		exited_d  = exited_q;
		status_d  = STATUS_OK;
		sig_d     = '0;
		mask_d    = '0;
		case (req_func_q)
			FUNC_RAISE: begin
				if (req_sig_q >= NumSigW) begin
					status_d = STATUS_INVAL;
				end else if (req_sig_q != 8'd0) begin
					pending_d = pending_q | (64'd1 << req_sig_q[5:0]);
					if (req_sig_q == SIG_STOP) begin
						run_d = RUN_STOPPED;
					end
					if (req_sig_q == SIG_CONT) begin
						run_d = RUN_RUNNING;
					end
					if (req_sig_q == SIG_TERM || req_sig_q == SIG_KILL ||
					    req_sig_q == SIG_INT) begin
						term_d   = req_sig_q[5:0];
						exited_d = 1'b1;
						run_d    = RUN_ZOMBIE;
					end
				end
			end
			FUNC_DEQUEUE: begin
				if (ready_bits != 64'd0) begin
					pending_d = pending_q & ~lowest_bit;
					sig_d     = lowest_idx;
				end else begin
					status_d = STATUS_AGAIN;
				end
			end
			FUNC_BLOCK: begin
				mask_d    = blocked_q;
				blocked_d = blocked_q | req_mask_q;
			end
			FUNC_UNBLOCK: begin
				mask_d    = blocked_q;
				blocked_d = blocked_q & ~req_mask_q;
			end
			FUNC_SET_MASK: begin
				mask_d    = blocked_q;
				blocked_d = req_mask_q;
			end
			FUNC_READ_PEND: begin
				mask_d = pending_q;
			end
			FUNC_CLEAR_PEND: begin
				pending_d = '0;
			end
			default: begin
				status_d = STATUS_INVAL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			blocked_q <= '0;
			run_q     <= RUN_RUNNING;
			term_q    <= '0;
			exited_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				pending_q <= pending_d;
				blocked_q <= blocked_d;
				run_q     <= run_d;
				term_q    <= term_d;
				exited_q  <= exited_d;
				out_vld_q <= 1'b1;
			end else if (res_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_status_q <= status_d;
			out_sig_q    <= sig_d;
			out_mask_q   <= mask_d;
		end
	end

	// The state registers only change on a commit, so they still match the waiting beat.
	assign stat.out_free = !out_vld_q || res_ready;
	assign res_valid     = out_vld_q;
	assign res_user      = out_status_q;
	assign res_data      = {1'b0, exited_q, term_q, run_q, out_mask_q, out_sig_q};

endmodule

// ----- rtl/signal_pending_mask_unit.sv -----
// Top level of the signal pending mask unit: controller, datapath and checks.
// A request beat is captured in the idle state and applied in the execute state, which
// loads the result register; a new request is taken only back in idle, and a result left
// waiting on m_tready holds the next request in execute.
// Reset: arst_n low clears both signal sets, the terminating signal and the exited flag,
// sets the run state to running and empties the result register.
`include "assert_macros.svh"

module signal_pending_mask_unit
	import sigpm_pkg::*;
#(
	parameter int NUM_SIGNALS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata, lowest bit up: signal_number[7:0], mask_value[71:8].
	input  logic [71:0] s_tdata,
	// s_tuser: func[2:0].
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata, lowest bit up: signal_out[5:0], mask_out[69:6], run_state[71:70],
	// term_signal[77:72], has_exited[78], zero fill[79].
	output logic [79:0] m_tdata,
	// m_tuser: status[1:0].
	output logic [1:0]  m_tuser
);

	sigpm_cmd_t  cmd;
	sigpm_stat_t stat;

	// The controller takes a request beat in idle and applies it in execute, as soon as
	// the result register is empty or being emptied in the same cycle.
	sigpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the captured request, the task's signal state and the result
	// beat; the execute state performs the mask update and the lowest-bit search.
	sigpm_dpath #(
		.NUM_SIGNALS (NUM_SIGNALS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_data  (s_tdata),
		.req_user  (s_tuser),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_data  (m_tdata),
		.res_user  (m_tuser)
	);

	// Only one request is in flight: after a request beat, the input side stays closed.
	`SIGPM_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second request taken while one is in flight")

	// A commit never overwrites a result beat that has not been taken.
	`SIGPM_ASSERT_IMP(a_no_overwrite, cmd.commit, !m_tvalid || m_tready, "result beat overwritten")

	// The exited flag only rises with a recorded terminating signal.
	`SIGPM_ASSERT_IMP(a_exit_term, m_tvalid && m_tdata[78], m_tdata[77:72] == 6'd2 || m_tdata[77:72] == 6'd9 || m_tdata[77:72] == 6'd15, "exited without a terminating signal")

	// A request that fails or finds nothing to take never reports a signal.
	`SIGPM_ASSERT_IMP(a_status_sig, m_tvalid && m_tuser != STATUS_OK, m_tdata[5:0] == 6'd0, "signal reported with a failing status")

endmodule

// ----- tb/signal_pending_mask_unit_tb.sv -----
// Self-checking testbench for the signal pending mask unit: directed and random requests.
`timescale 1ns / 100ps

module signal_pending_mask_unit_tb;
	import sigpm_pkg::*;

	// Number of signals that the block is built for.
	localparam int SIG_COUNT = 64;
	// The one request code that the function field allows but the block does not define.
	localparam logic [2:0] FUNC_UNDEFINED = 3'd7;
	// How many mismatches are reported in full before they are only counted.
	localparam int REPORT_LIMIT = 10;
	// Cycles to wait after the last result for any stray beat.
	localparam int DRAIN_CYCLES = 16;

	// One result beat, unpacked into its fields.
	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  signal_out;
		logic [63:0] mask_out;
		logic [1:0]  run_state;
		logic [5:0]  term_signal;
		logic        has_exited;
	} sigpm_result_t;

	// Tracks the signal sets and run state of the task, and holds the results that the
	// block still owes, oldest first.
	class pending_mask_tracker;
		logic [63:0]   pending_set;
		logic [63:0]   blocked_set;
		sigpm_run_t    run_st;
		logic [5:0]    term_sig;
		logic          exited;
		sigpm_result_t owed_results[$];
		int            mismatches;
		int            checked;
		int            empty_dequeues;

		function new();
			pending_set    = '0;
			blocked_set    = '0;
			run_st         = RUN_RUNNING;
			term_sig       = '0;
			exited         = 1'b0;
			mismatches     = 0;
			checked        = 0;
			empty_dequeues = 0;
		endfunction

		// Applies one accepted request to the tracked state and queues the result it owes.
		function void note_request(logic [2:0] func, logic [7:0] sig, logic [63:0] mval);
			sigpm_result_t res;
			logic [63:0]   ready;
			bit            found;
			res        = '0;
			res.status = STATUS_OK;
			found      = 1'b0;
			case (func)
				FUNC_RAISE: begin
					if (sig >= SIG_COUNT) begin
						res.status = STATUS_INVAL;
					end else if (sig != 8'd0) begin
						pending_set[sig[5:0]] = 1'b1;
						if (sig == SIG_STOP)
							run_st = RUN_STOPPED;
						if (sig == SIG_CONT)
							run_st = RUN_RUNNING;
						if (sig == SIG_TERM || sig == SIG_KILL || sig == SIG_INT) begin
							term_sig = sig[5:0];
							exited   = 1'b1;
							run_st   = RUN_ZOMBIE;
						end
					end
				end
				FUNC_DEQUEUE: begin
					// Lowest deliverable signal from 1 up; signal 0 is never taken.
					ready = pending_set & ~blocked_set & ~mval;
					for (int n = 1; n < SIG_COUNT; n++) begin
						if (!found && ready[n]) begin
							found          = 1'b1;
							pending_set[n] = 1'b0;
							res.signal_out = n[5:0];
						end
					end
					if (!found) begin
						res.status = STATUS_AGAIN;
						empty_dequeues++;
					end
				end
				FUNC_BLOCK: begin
					res.mask_out = blocked_set;
					blocked_set  = blocked_set | mval;
				end
				FUNC_UNBLOCK: begin
					res.mask_out = blocked_set;
					blocked_set  = blocked_set & ~mval;
				end
				FUNC_SET_MASK: begin
					res.mask_out = blocked_set;
					blocked_set  = mval;
				end
				FUNC_READ_PEND: res.mask_out = pending_set;
				FUNC_CLEAR_PEND: pending_set = '0;
				default: res.status = STATUS_INVAL;
			endcase
			res.run_state   = run_st;
			res.term_signal = term_sig;
			res.has_exited  = exited;
			owed_results.push_back(res);
		endfunction

		// Compares one accepted result beat, field by field, with the oldest owed result.
		function void check_result(logic [79:0] data, logic [1:0] user);
			sigpm_result_t act;
			sigpm_result_t exp;
			act.status      = user;
			act.signal_out  = data[5:0];
			act.mask_out    = data[69:6];
			act.run_state   = data[71:70];
			act.term_signal = data[77:72];
			act.has_exited  = data[78];
			checked++;
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: result beat with nothing owed: status %0d signal %0d mask %h",
						$time, act.status, act.signal_out, act.mask_out);
				return;
			end
			exp = owed_results.pop_front();
			if (act.status !== exp.status || act.signal_out !== exp.signal_out ||
					act.mask_out !== exp.mask_out || act.run_state !== exp.run_state ||
					act.term_signal !== exp.term_signal || act.has_exited !== exp.has_exited)
					begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: mismatch on result %0d", $time, checked);
					$display("  expected: status %0d signal %0d mask %h run %0d term %0d exit %0d",
						exp.status, exp.signal_out, exp.mask_out, exp.run_state,
						exp.term_signal, exp.has_exited);
					$display("  actual:   status %0d signal %0d mask %h run %0d term %0d exit %0d",
						act.status, act.signal_out, act.mask_out, act.run_state,
						act.term_signal, act.has_exited);
				end
			end
		endfunction

		function int outstanding();
			return owed_results.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;

	pending_mask_tracker tracker;

	// When set, neither side idles, so that back-to-back beats are exercised too.
	bit burst_mode;
	// Accepted requests per function code, for the closing summary.
	int func_seen[8];

	signal_pending_mask_unit #(
		.NUM_SIGNALS(SIG_COUNT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// 12 ns clock, low then high.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Cycles a side waits before its next beat; none at all in burst mode.
	function automatic int idle_cycles();
		if (burst_mode)
			return 0;
		return $urandom_range(0, 9);
	endfunction

	// A mask drawn with a bias towards sparse values, so that dequeues and masks interact
	// with only a few signals at a time and the lowest-first search is exercised.
	function automatic logic [63:0] random_mask();
		int          pick;
		logic [63:0] full;
		pick = $urandom_range(0, 99);
		full = {$urandom(), $urandom()};
		if (pick < 30)
			return '0;
		if (pick < 55)
			return 64'd1 << $urandom_range(0, 63);
		if (pick < 75)
			return full & {$urandom(), $urandom()} & {$urandom(), $urandom()};
		if (pick < 90)
			return full;
		return '1;
	endfunction

	// Presents one request beat and holds it until the block takes it. Entered and left
	// just after a falling edge, so the inputs only ever change there.
	task automatic send_request(input logic [2:0] func, input logic [7:0] sig,
			input logic [63:0] mval);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser  = func;
		s_tdata  = {mval, sig};
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		// Accepted at this edge: update the prediction before the result can appear.
		tracker.note_request(func, sig, mval);
		func_seen[func]++;
		@(negedge clk);
	endtask

	// One random request: raises and dequeues dominate so that the pending set keeps
	// filling and draining, with mask changes, reads and clears mixed in.
	task automatic send_random_request();
		int          pick;
		int          sig_pick;
		logic [2:0]  func;
		logic [7:0]  sig;
		logic [63:0] mval;
		pick     = $urandom_range(0, 99);
		sig_pick = $urandom_range(0, 99);
		if (pick < 30)
			func = FUNC_RAISE;
		else if (pick < 55)
			func = FUNC_DEQUEUE;
		else if (pick < 62)
			func = FUNC_BLOCK;
		else if (pick < 69)
			func = FUNC_UNBLOCK;
		else if (pick < 76)
			func = FUNC_SET_MASK;
		else if (pick < 88)
			func = FUNC_READ_PEND;
		else if (pick < 95)
			func = FUNC_CLEAR_PEND;
		else
			func = FUNC_UNDEFINED;
		// Mostly valid numbers, some with a fixed effect on the run state, and a share
		// across the whole byte so that out-of-range numbers come up too.
		if (sig_pick < 75) begin
			sig = 8'($urandom_range(0, SIG_COUNT - 1));
		end else if (sig_pick < 88) begin
			case ($urandom_range(0, 5))
				0: sig = 8'd0;
				1: sig = SIG_STOP;
				2: sig = SIG_CONT;
				3: sig = SIG_TERM;
				4: sig = SIG_KILL;
				default: sig = SIG_INT;
			endcase
		end else begin
			sig = 8'($urandom_range(0, 255));
		end
		mval = random_mask();
		send_request(func, sig, mval);
	endtask

	// Result side: draws a stall for every beat, then waits for the beat and checks it.
	// Like the sender, it only changes m_tready just after a falling edge.
	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = idle_cycles();
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
			tracker.check_result(m_tdata, m_tuser);
			@(negedge clk);
		end
	end

	// Guard against a hung handshake. The limit allows for the slowest correct run, with both
	// sides at their longest waits on every request.
	initial begin : watchdog
		#5_000_000;
		$display("signal_pending_mask_unit regression: fail");
		$finish;
	end

	initial begin : stimulus
		tracker    = new();
		burst_mode = 1'b0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = FUNC_RAISE;
		// Hold reset over rising edges, then release it at a falling edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part. Start from the reset state: nothing pending, nothing to take.
		send_request(FUNC_READ_PEND, 8'd0, '0);
		send_request(FUNC_DEQUEUE, 8'd0, '0);
		// Signal zero is accepted and changes nothing; numbers past the range are refused.
		send_request(FUNC_RAISE, 8'd0, '0);
		send_request(FUNC_RAISE, 8'(SIG_COUNT), '0);
		send_request(FUNC_RAISE, 8'hFF, '1);
		// Highest and lowest valid signals, then stop and continue.
		send_request(FUNC_RAISE, 8'(SIG_COUNT - 1), '0);
		send_request(FUNC_RAISE, 8'd1, '0);
		send_request(FUNC_RAISE, SIG_STOP, '0);
		send_request(FUNC_RAISE, SIG_CONT, '0);
		send_request(FUNC_RAISE, SIG_STOP, '0);
		// Everything excluded, then everything blocked: nothing is deliverable either way.
		send_request(FUNC_DEQUEUE, 8'd0, '1);
		send_request(FUNC_BLOCK, 8'd0, '1);
		send_request(FUNC_DEQUEUE, 8'd0, '0);
		// Unblock all but the lowest signal; the search must skip over it.
		send_request(FUNC_UNBLOCK, 8'd0, 64'hFFFF_FFFF_FFFF_FFFD);
		send_request(FUNC_DEQUEUE, 8'd0, 64'd1);
		send_request(FUNC_SET_MASK, 8'd0, '0);
		send_request(FUNC_DEQUEUE, 8'd0, '0);
		// The three terminating signals, then stop while a zombie, then read, clear and read again.
		send_request(FUNC_RAISE, SIG_TERM, '0);
		send_request(FUNC_RAISE, SIG_KILL, '0);
		send_request(FUNC_RAISE, SIG_INT, '0);
		send_request(FUNC_RAISE, SIG_STOP, '0);
		send_request(FUNC_READ_PEND, 8'd0, '0);
		send_request(FUNC_CLEAR_PEND, 8'd0, '1);
		send_request(FUNC_READ_PEND, 8'd0, '0);
		// The undefined request code is refused.
		send_request(FUNC_UNDEFINED, 8'hA5, '1);

		// Random part in phases; every third phase runs with no idling on either side.
		for (int phase = 0; phase < 9; phase++) begin
			burst_mode = (phase % 3 == 2);
			repeat (150) send_random_request();
		end
		burst_mode = 1'b0;
		s_tvalid   = 1'b0;

		// Drain: wait for every owed result, then a little longer for any stray beat.
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d raises, %0d dequeues (%0d with nothing to take), %0d mask updates,",
			func_seen[FUNC_RAISE], func_seen[FUNC_DEQUEUE], tracker.empty_dequeues,
			func_seen[FUNC_BLOCK] + func_seen[FUNC_UNBLOCK] + func_seen[FUNC_SET_MASK]);
		$display("%0d reads, %0d clears and %0d undefined requests; %0d results checked.",
			func_seen[FUNC_READ_PEND], func_seen[FUNC_CLEAR_PEND],
			func_seen[FUNC_UNDEFINED], tracker.checked);
		if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
			$display("signal_pending_mask_unit regression: pass");
		end else begin
			$display("%0d mismatches, %0d results never arrived", tracker.mismatches,
				tracker.outstanding());
			$display("signal_pending_mask_unit regression: fail");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/sigpm_pkg.sv
rtl/sigpm_ctrl.sv
rtl/sigpm_dpath.sv
rtl/signal_pending_mask_unit.sv
tb/signal_pending_mask_unit_tb.sv
